// File: hdl/sfce_pkg.sv
// Shared types, codes and constants for the serial flow control engine.
package sfce_pkg;

    // Stream payload widths.
    localparam int S_TDATA_W = 16;
    localparam int S_TUSER_W = 4;
    localparam int M_TDATA_W = 32;
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 8;
    localparam int RX_COUNT_W = 7;

    // Item kinds carried on s_tuser.
    localparam logic [S_TUSER_W-1:0] KIND_RX_BYTE  = 4'd0;
    localparam logic [S_TUSER_W-1:0] KIND_TX_EMPTY = 4'd1;
    localparam logic [S_TUSER_W-1:0] KIND_MODEM    = 4'd2;
    localparam logic [S_TUSER_W-1:0] KIND_LOAD     = 4'd3;
    localparam logic [S_TUSER_W-1:0] KIND_DRAIN    = 4'd4;
    localparam logic [S_TUSER_W-1:0] KIND_INHIBIT  = 4'd5;
    localparam logic [S_TUSER_W-1:0] KIND_CREADY   = 4'd6;
    localparam logic [S_TUSER_W-1:0] KIND_CANCEL   = 4'd7;
    localparam logic [S_TUSER_W-1:0] KIND_HUPQ     = 4'd8;

    // Configuration register indexes.
    localparam logic [CFG_ADDR_W-1:0] CFG_XOFF_CHAR = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_RAW_MODE  = 1'b1;

    localparam logic [7:0] XOFF_RESET = 8'd19;
    localparam logic       RAW_RESET  = 1'b1;

    // Line flag bits.
    localparam int FL_DONE   = 0;
    localparam int FL_QUEUED = 1;
    localparam int FL_SWRDY  = 2;
    localparam int FL_CTS    = 3;
    localparam int FL_HUP    = 4;
    localparam logic [4:0] FLAGS_RESET = 5'b00100;

    // Controller states.
    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_EXEC = 6'b000010,
        ST_SEND = 6'b000100,
        ST_EMIT = 6'b001000,
        ST_DRD  = 6'b010000,
        ST_DOUT = 6'b100000
    } sfce_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic exec;
        logic send;
        logic emit;
        logic drain_rd;
        logic drain_load;
    } sfce_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic send_pend;
        logic drain;
        logic drain_empty;
        logic drain_last;
        logic out_free;
    } sfce_stat_t;

    // Packs one result item, first field in the lowest bits.
    function automatic logic [M_TDATA_W-1:0] pack_result(
        input logic                  tx_valid,
        input logic [7:0]            tx_byte,
        input logic                  rts,
        input logic [7:0]            rx_byte,
        input logic [RX_COUNT_W-1:0] rx_count,
        input logic                  out_done,
        input logic                  hangup
    );
        return {5'd0, hangup, out_done, rx_count, rx_byte, rts, tx_byte, tx_valid};
    endfunction

endpackage

// File: hdl/sfce_ram.sv
// Generic single-write, single-read RAM with registered read data.
module sfce_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: hdl/sfce_ctrl.sv
// Controller state machine that sequences one item at a time through the datapath.
module sfce_ctrl
    import sfce_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  sfce_stat_t stat,
    output sfce_cmd_t  cmd
);

    sfce_state_t state_reg, state_next;

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and command decode.
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                cmd.exec = 1'b1;
                if (stat.drain) begin
                    state_next = stat.drain_empty ? ST_EMIT : ST_DRD;
                end else begin
                    state_next = stat.send_pend ? ST_SEND : ST_EMIT;
                end
            end
            ST_SEND: begin
                cmd.send   = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (stat.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_DRD: begin
                cmd.drain_rd = 1'b1;
                state_next   = ST_DOUT;
            end
            ST_DOUT: begin
                if (stat.out_free) begin
                    cmd.drain_load = 1'b1;
                    if (stat.drain_last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // A result is only loaded when the output register can take it.
    a_load_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.emit || cmd.drain_load) |-> stat.out_free)
        else $error("result loaded while output register busy");

    // Only one item is in work at a time.
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second item accepted while one is in work");

endmodule

// File: hdl/sfce_datapath.sv
// Datapath: item register, line state, input and output stores, and result register.
module sfce_datapath
    import sfce_pkg::*;
#(
    parameter int IN_DEPTH  = 32,
    parameter int HIGH_MARK = 24,
    parameter int OUT_DEPTH = 64
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  sfce_cmd_t             cmd,
    output sfce_stat_t            stat,
    input  logic [S_TDATA_W-1:0]  s_tdata,
    input  logic [S_TUSER_W-1:0]  s_tuser,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,
    output logic                  m_tlast
);

    localparam int IN_AW  = $clog2(IN_DEPTH);
    localparam int IN_CW  = $clog2(IN_DEPTH + 1);
    localparam int OUT_AW = $clog2(OUT_DEPTH);
    localparam int OUT_CW = $clog2(OUT_DEPTH + 1);
    localparam logic [7:0]        HMARK8    = 8'(HIGH_MARK);
    localparam logic [IN_CW-1:0]  IN_FULL   = IN_CW'(IN_DEPTH);
    localparam logic [OUT_CW-1:0] OUT_FULL  = OUT_CW'(OUT_DEPTH);

    // Configuration registers.
    logic [7:0] xoff_reg;
    logic       raw_reg;

    // Item register.
    logic [S_TUSER_W-1:0] kind_reg;
    logic [7:0]           byte_reg;
    logic                 flag_reg, txr_reg, cts_reg, car_reg, dcar_reg;

    // Line state.
    logic [IN_CW-1:0]  fill_reg, fill_next;
    logic              rts_reg, rts_next;
    logic              cr_reg, cr_next;
    logic [OUT_CW-1:0] head_reg, head_next;
    logic [OUT_CW-1:0] tail_reg, tail_next;
    logic [4:0]        flags_reg, flags_next;

    // Per-item work state.
    logic              hup_reg, hup_next;
    logic              sent_reg, sent_next;
    logic [IN_CW-1:0]  cnt_reg, cnt_next;
    logic [IN_AW-1:0]  idx_reg, idx_next;

    // Output register.
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic                 m_tlast_reg, m_tlast_next;

    // Store ports.
    logic             in_we, in_re;
    logic [IN_AW-1:0] in_raddr;
    logic [7:0]       in_rdata;
    logic             out_we, out_re;
    logic [7:0]       out_rdata;

    logic              send_pend;
    logic              can_send;
    logic [OUT_CW-1:0] head_inc;
    logic [7:0]        fill_inc8;
    logic              drain_last;
    logic              out_free;

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            xoff_reg <= XOFF_RESET;
            raw_reg  <= RAW_RESET;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                CFG_XOFF_CHAR: xoff_reg <= cfg_wdata;
                CFG_RAW_MODE:  raw_reg  <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // Capture the accepted item.
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            kind_reg <= s_tuser;
            byte_reg <= s_tdata[7:0];
            flag_reg <= s_tdata[8];
            txr_reg  <= s_tdata[9];
            cts_reg  <= s_tdata[10];
            car_reg  <= s_tdata[11];
            dcar_reg <= s_tdata[12];
        end
    end

    // Control state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg     <= '0;
            rts_reg      <= 1'b1;
            cr_reg       <= 1'b1;
            head_reg     <= '0;
            tail_reg     <= '0;
            flags_reg    <= FLAGS_RESET;
            m_tvalid_reg <= 1'b0;
        end else begin
            fill_reg     <= fill_next;
            rts_reg      <= rts_next;
            cr_reg       <= cr_next;
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            flags_reg    <= flags_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Work and payload registers.
    always_ff @(posedge aclk) begin
        hup_reg     <= hup_next;
        sent_reg    <= sent_next;
        cnt_reg     <= cnt_next;
        idx_reg     <= idx_next;
        m_tdata_reg <= m_tdata_next;
        m_tlast_reg <= m_tlast_next;
    end

    assign fill_inc8  = 8'(fill_reg) + 8'd1;
    assign drain_last = (IN_CW'(idx_reg) + IN_CW'(1)) == cnt_reg;
    assign out_free   = !m_tvalid_reg || m_tready;
    assign can_send   = (head_reg < tail_reg) && (head_reg < OUT_FULL);
    assign head_inc   = head_reg + OUT_CW'(can_send);

    // Item execution, transmit attempt, drain walk and result loading.
    always_comb begin
        fill_next     = fill_reg;
        rts_next      = rts_reg;
        cr_next       = cr_reg;
        head_next     = head_reg;
        tail_next     = tail_reg;
        flags_next    = flags_reg;
        hup_next      = hup_reg;
        sent_next     = sent_reg;
        cnt_next      = cnt_reg;
        idx_next      = idx_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tlast_next  = m_tlast_reg;
        send_pend     = 1'b0;
        in_we         = 1'b0;
        out_we        = 1'b0;
        in_re         = 1'b0;
        in_raddr      = idx_reg;
        out_re        = 1'b0;

        // Apply the item's own effect on the line state.
        if (cmd.exec) begin
            hup_next  = 1'b0;
            sent_next = 1'b0;
            unique case (kind_reg)
                KIND_RX_BYTE: begin
                    if (!raw_reg) begin
                        if (byte_reg == xoff_reg) begin
                            flags_next[FL_SWRDY] = 1'b0;
                        end else if (!flags_reg[FL_SWRDY]) begin
                            flags_next[FL_SWRDY] = 1'b1;
                            send_pend = txr_reg;
                        end
                    end
                    if (fill_reg < IN_FULL) begin
                        in_we     = 1'b1;
                        fill_next = fill_reg + IN_CW'(1);
                        if (fill_inc8 == HMARK8) begin
                            rts_next = 1'b0;
                        end
                    end
                end
                KIND_TX_EMPTY: begin
                    send_pend = 1'b1;
                end
                KIND_MODEM: begin
                    if (dcar_reg && !car_reg) begin
                        flags_next[FL_HUP] = 1'b1;
                    end
                    if (!cts_reg) begin
                        flags_next[FL_CTS] = 1'b0;
                    end else if (!flags_reg[FL_CTS]) begin
                        flags_next[FL_CTS] = 1'b1;
                        send_pend = txr_reg;
                    end
                end
                KIND_LOAD: begin
                    if (!flags_reg[FL_QUEUED]) begin
                        if (tail_reg < OUT_FULL) begin
                            out_we    = 1'b1;
                            tail_next = tail_reg + OUT_CW'(1);
                        end
                        if (flag_reg) begin
                            flags_next[FL_QUEUED] = 1'b1;
                            send_pend = txr_reg;
                        end
                    end
                end
                KIND_DRAIN: begin
                    cnt_next  = fill_reg;
                    fill_next = '0;
                    idx_next  = '0;
                    if (!rts_reg && cr_reg) begin
                        rts_next = 1'b1;
                    end
                end
                KIND_INHIBIT: begin
                    flags_next[FL_SWRDY] = !flag_reg;
                end
                KIND_CREADY: begin
                    if (flag_reg) begin
                        cr_next = 1'b1;
                        if (8'(fill_reg) < HMARK8) begin
                            rts_next = 1'b1;
                        end
                    end else begin
                        cr_next  = 1'b0;
                        rts_next = 1'b0;
                    end
                end
                KIND_CANCEL: begin
                    flags_next[FL_DONE]   = 1'b0;
                    flags_next[FL_QUEUED] = 1'b0;
                    head_next = '0;
                    tail_next = '0;
                end
                KIND_HUPQ: begin
                    if (flags_reg[FL_HUP]) begin
                        hup_next = 1'b1;
                        flags_next[FL_HUP] = 1'b0;
                    end
                end
                default: ;
            endcase
        end

        // Transmit attempt: read the head byte and retire the queue when empty.
        if (cmd.send) begin
            if (flags_reg[FL_CTS] && flags_reg[FL_QUEUED] && flags_reg[FL_SWRDY]) begin
                out_re    = can_send;
                sent_next = can_send;
                if (head_inc >= tail_reg) begin
                    flags_next[FL_DONE]   = 1'b1;
                    flags_next[FL_QUEUED] = 1'b0;
                    head_next = '0;
                    tail_next = '0;
                end else begin
                    head_next = head_inc;
                end
            end
        end

        // Drain walk: the read of the next byte overlaps the load of this one.
        if (cmd.drain_rd) begin
            in_re    = 1'b1;
            in_raddr = idx_reg;
        end
        if (cmd.drain_load) begin
            in_re        = !drain_last;
            in_raddr     = idx_reg + IN_AW'(1);
            idx_next     = idx_reg + IN_AW'(1);
            m_tvalid_next = 1'b1;
            m_tlast_next  = drain_last;
            m_tdata_next  = pack_result(1'b0, 8'd0, rts_reg, in_rdata,
                                        RX_COUNT_W'(cnt_reg), flags_reg[FL_DONE], 1'b0);
        end

        // Single result of a non-drain item or an empty drain.
        if (cmd.emit) begin
            m_tvalid_next = 1'b1;
            m_tlast_next  = 1'b1;
            m_tdata_next  = pack_result(sent_reg, sent_reg ? out_rdata : 8'd0, rts_reg,
                                        8'd0, RX_COUNT_W'(0), flags_reg[FL_DONE],
                                        hup_reg);
        end
    end

    sfce_ram #(
        .WIDTH(8),
        .DEPTH(IN_DEPTH)
    ) u_in_ram (
        .aclk  (aclk),
        .we    (in_we),
        .waddr (fill_reg[IN_AW-1:0]),
        .wdata (byte_reg),
        .re    (in_re),
        .raddr (in_raddr),
        .rdata (in_rdata)
    );

    sfce_ram #(
        .WIDTH(8),
        .DEPTH(OUT_DEPTH)
    ) u_out_ram (
        .aclk  (aclk),
        .we    (out_we),
        .waddr (tail_reg[OUT_AW-1:0]),
        .wdata (byte_reg),
        .re    (out_re),
        .raddr (head_reg[OUT_AW-1:0]),
        .rdata (out_rdata)
    );

    assign stat.send_pend   = send_pend;
    assign stat.drain       = (kind_reg == KIND_DRAIN);
    assign stat.drain_empty = (fill_reg == '0);
    assign stat.drain_last  = drain_last;
    assign stat.out_free    = out_free;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    // The input fill never passes the store size.
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= IN_FULL)
        else $error("input fill beyond store size");

    // Sent bytes never overtake loaded bytes.
    a_head_tail: assert property (@(posedge aclk) disable iff (!aresetn)
        head_reg <= tail_reg)
        else $error("output head passed tail");

    // Nothing is sent unless output is queued, so the head rests at zero.
    a_head_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        !flags_reg[FL_QUEUED] |-> head_reg == '0)
        else $error("output head moved while nothing queued");

endmodule

// File: hdl/serial_flow_control_engine_top.sv
// A non-drain item passes through the execute and emit states, with a send state between when it tries a send;
// emit waits for a free output register. A drain of n buffered bytes gives n results, one per cycle while the
// output is not stalled; an empty drain gives one result. Items are handled one at a time; the next item is
// taken once the last result is registered.
// Reset: aresetn is synchronous and active low; stores are not cleared, so no clearing pass.
module serial_flow_control_engine_top
    import sfce_pkg::*;
#(
    parameter int IN_DEPTH  = 32,
    parameter int HIGH_MARK = 24,
    parameter int OUT_DEPTH = 64
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // data_byte, flag, tx_ready, cts, carrier, carrier_delta, zero fill
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // kind
    input  logic [S_TUSER_W-1:0]  s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // tx_valid, tx_byte, rts, rx_byte, rx_count, out_done, hangup, zero fill
    output logic [M_TDATA_W-1:0]  m_tdata,
    output logic                  m_tlast,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    sfce_cmd_t  cmd;
    sfce_stat_t stat;

    sfce_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    sfce_datapath #(
        .IN_DEPTH  (IN_DEPTH),
        .HIGH_MARK (HIGH_MARK),
        .OUT_DEPTH (OUT_DEPTH)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

// File: test/serial_flow_control_engine_top_tb.sv
// Self-checking testbench for the serial flow control engine top level.
module serial_flow_control_engine_top_tb;
    import sfce_pkg::*;

    localparam int IN_DEPTH      = 32;
    localparam int HIGH_MARK     = 24;
    localparam int OUT_DEPTH     = 64;
    localparam int SETTLE_CYCLES = 8;
    localparam int ITEM_GOAL     = 310;
    localparam int KIND_TOP      = (1 << S_TUSER_W) - 1;

    // One line event as presented on the input stream.
    typedef struct {
        logic [S_TUSER_W-1:0] kind;
        logic [7:0]           data_byte;
        logic                 flag;
        logic                 tx_ready;
        logic                 cts;
        logic                 carrier;
        logic                 carrier_delta;
    } line_item_t;

    // One result item, unpacked.
    typedef struct {
        logic                  tx_valid;
        logic [7:0]            tx_byte;
        logic                  rts;
        logic [7:0]            rx_byte;
        logic [RX_COUNT_W-1:0] rx_count;
        logic                  out_done;
        logic                  hangup;
        logic                  last;
    } reply_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata = '0;
    logic [S_TUSER_W-1:0]  s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tlast;
    logic                  cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    // Stimulus waiting to be sent and results waiting to arrive.
    line_item_t pending_items[$];
    reply_t     awaited_replies[$];
    int         items_built = 0;
    int         items_sent = 0;
    int         results_seen = 0;
    int         err_count = 0;

    // Idle control for both stream sides.
    int src_gap = 0;
    bit src_steady = 1'b0;
    int sink_stall = 0;
    bit sink_steady = 1'b0;
    int sink_cycles = 0;

    // Predicted engine state.
    logic [7:0] rx_buf[IN_DEPTH];
    logic [7:0] tx_buf[OUT_DEPTH];
    int         rx_fill;
    int         tx_head;
    int         tx_tail;
    logic       rts_now;
    logic       reader_ready;
    logic [4:0] lflags;
    logic [7:0] xoff_byte;
    logic       raw_on;
    logic       sent_valid;
    logic [7:0] sent_byte;

    serial_flow_control_engine_top #(
        .IN_DEPTH (IN_DEPTH),
        .HIGH_MARK(HIGH_MARK),
        .OUT_DEPTH(OUT_DEPTH)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_wdata(cfg_wdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Hard stop in case the engine hangs.
    initial begin
        #40_000_000;
        $display("serial_flow_control_engine_top_tb: done, errors");
        $finish;
    end

    task automatic note_mismatch(input string what);
        err_count++;
        $display("MISMATCH at %0t: %s", $realtime, what);
    endtask

    task automatic check_field(input string name, input int unsigned got,
                               input int unsigned want);
        if (got != want) begin
            note_mismatch($sformatf("result %0d field %s: got %0h, want %0h",
                                    results_seen, name, got, want));
        end
    endtask

    // Mostly short gaps, now and then a long one.
    function automatic int draw_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    // Sends one queued output byte if CTS, software ready and queued all hold.
    function automatic void attempt_send();
        if (!(lflags[FL_CTS] && lflags[FL_QUEUED] && lflags[FL_SWRDY])) begin
            return;
        end
        if (tx_head < tx_tail && tx_head < OUT_DEPTH) begin
            sent_valid = 1'b1;
            sent_byte  = tx_buf[tx_head];
            tx_head++;
        end
        // Completion empties the output store and leaves done set.
        if (tx_head >= tx_tail) begin
            lflags[FL_DONE]   = 1'b1;
            lflags[FL_QUEUED] = 1'b0;
            tx_head = 0;
            tx_tail = 0;
        end
    endfunction

    function automatic reply_t form_reply(input logic [7:0] rxb, input int cnt,
                                          input logic hup, input logic fin);
        reply_t r;
        r.tx_valid = sent_valid;
        r.tx_byte  = sent_valid ? sent_byte : 8'd0;
        r.rts      = rts_now;
        r.rx_byte  = rxb;
        r.rx_count = RX_COUNT_W'(cnt);
        r.out_done = lflags[FL_DONE];
        r.hangup   = hup;
        r.last     = fin;
        return r;
    endfunction

    // Advances the predicted engine by one accepted item and queues its results.
    function automatic void apply_line_item(input line_item_t it);
        logic hup;
        int   n;
        hup        = 1'b0;
        sent_valid = 1'b0;
        sent_byte  = 8'd0;
        case (it.kind)
            KIND_RX_BYTE: begin
                // Software flow control: the XOFF byte pauses, any other byte resumes.
                if (!raw_on) begin
                    if (it.data_byte == xoff_byte) begin
                        lflags[FL_SWRDY] = 1'b0;
                    end else if (!lflags[FL_SWRDY]) begin
                        lflags[FL_SWRDY] = 1'b1;
                        if (it.tx_ready) attempt_send();
                    end
                end
                if (rx_fill < IN_DEPTH) begin
                    rx_buf[rx_fill] = it.data_byte;
                    rx_fill++;
                    if (rx_fill == HIGH_MARK) rts_now = 1'b0;
                end
            end
            KIND_TX_EMPTY: begin
                attempt_send();
            end
            KIND_MODEM: begin
                if (it.carrier_delta && !it.carrier) lflags[FL_HUP] = 1'b1;
                if (!it.cts) begin
                    lflags[FL_CTS] = 1'b0;
                end else if (!lflags[FL_CTS]) begin
                    lflags[FL_CTS] = 1'b1;
                    if (it.tx_ready) attempt_send();
                end
            end
            KIND_LOAD: begin
                // Loads are ignored while earlier output is still queued.
                if (!lflags[FL_QUEUED]) begin
                    if (tx_tail < OUT_DEPTH) begin
                        tx_buf[tx_tail] = it.data_byte;
                        tx_tail++;
                    end
                    if (it.flag) begin
                        lflags[FL_QUEUED] = 1'b1;
                        if (it.tx_ready) attempt_send();
                    end
                end
            end
            KIND_DRAIN: begin
                n = rx_fill;
                rx_fill = 0;
                if (!rts_now && reader_ready) rts_now = 1'b1;
                if (n == 0) begin
                    awaited_replies.push_back(form_reply(8'd0, 0, 1'b0, 1'b1));
                end else begin
                    for (int i = 0; i < n; i++) begin
                        awaited_replies.push_back(form_reply(rx_buf[i], n, 1'b0, i == n - 1));
                    end
                end
                return;
            end
            KIND_INHIBIT: begin
                lflags[FL_SWRDY] = !it.flag;
            end
            KIND_CREADY: begin
                if (it.flag) begin
                    reader_ready = 1'b1;
                    if (rx_fill < HIGH_MARK) rts_now = 1'b1;
                end else begin
                    reader_ready = 1'b0;
                    rts_now = 1'b0;
                end
            end
            KIND_CANCEL: begin
                lflags[FL_DONE]   = 1'b0;
                lflags[FL_QUEUED] = 1'b0;
                tx_head = 0;
                tx_tail = 0;
            end
            KIND_HUPQ: begin
                if (lflags[FL_HUP]) begin
                    hup = 1'b1;
                    lflags[FL_HUP] = 1'b0;
                end
            end
            default: begin
            end
        endcase
        awaited_replies.push_back(form_reply(8'd0, 0, hup, 1'b1));
    endfunction

    // Input stream driver: holds each item until it is taken, then maybe idles.
    always @(posedge aclk) begin : feed
        logic next_valid;
        next_valid = 1'b0;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                apply_line_item(pending_items.pop_front());
                items_sent++;
                if (items_sent % 40 == 0) src_steady = ($urandom_range(0, 2) == 0);
                src_gap = src_steady ? 0 : draw_gap();
            end
            if (s_tvalid && !s_tready) begin
                next_valid = 1'b1;
            end else if (src_gap != 0) begin
                src_gap--;
            end else if (pending_items.size() != 0) begin
                next_valid = 1'b1;
            end
        end
        if (next_valid) begin
            s_tvalid <= 1'b1;
            s_tuser  <= pending_items[0].kind;
            s_tdata  <= {3'b000, pending_items[0].carrier_delta, pending_items[0].carrier,
                         pending_items[0].cts, pending_items[0].tx_ready,
                         pending_items[0].flag, pending_items[0].data_byte};
        end else begin
            s_tvalid <= 1'b0;
        end
    end

    // Result monitor: compares each item with the oldest prediction and stalls at random.
    always @(posedge aclk) begin : sink
        reply_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (awaited_replies.size() == 0) begin
                note_mismatch($sformatf("result with nothing expected, tdata %h", m_tdata));
            end else begin
                want = awaited_replies.pop_front();
                check_field("tx_valid", 32'(m_tdata[0]), 32'(want.tx_valid));
                check_field("tx_byte", 32'(m_tdata[8:1]), 32'(want.tx_byte));
                check_field("rts", 32'(m_tdata[9]), 32'(want.rts));
                check_field("rx_byte", 32'(m_tdata[17:10]), 32'(want.rx_byte));
                check_field("rx_count", 32'(m_tdata[24:18]), 32'(want.rx_count));
                check_field("out_done", 32'(m_tdata[25]), 32'(want.out_done));
                check_field("hangup", 32'(m_tdata[26]), 32'(want.hangup));
                check_field("last", 32'(m_tlast), 32'(want.last));
                results_seen++;
            end
        end
        sink_cycles++;
        if (sink_cycles % 500 == 0) sink_steady = ($urandom_range(0, 2) == 0);
        if (sink_stall != 0) begin
            sink_stall--;
            m_tready <= 1'b0;
        end else if (!sink_steady && $urandom_range(0, 99) < 25) begin
            sink_stall = draw_gap();
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    function automatic line_item_t line_item(input logic [S_TUSER_W-1:0] kind,
                                             input logic [7:0] data_byte, input int flag,
                                             input int tx_ready, input int cts,
                                             input int carrier, input int carrier_delta);
        line_item_t it;
        it.kind          = kind;
        it.data_byte     = data_byte;
        it.flag          = 1'(flag);
        it.tx_ready      = 1'(tx_ready);
        it.cts           = 1'(cts);
        it.carrier       = 1'(carrier);
        it.carrier_delta = 1'(carrier_delta);
        return it;
    endfunction

    function automatic line_item_t random_item(input int kind);
        return line_item(S_TUSER_W'(kind), 8'($urandom_range(0, 255)), $urandom_range(0, 1),
                         $urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 1),
                         $urandom_range(0, 1));
    endfunction

    task automatic queue_item(input line_item_t it);
        pending_items.push_back(it);
        items_built++;
    endtask

    // Waits until the engine has delivered everything, then lets it settle.
    task automatic settle_idle();
        do begin
            @(posedge aclk);
        end while (pending_items.size() != 0 || awaited_replies.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [7:0] value);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= value;
        if (addr == CFG_XOFF_CHAR) begin
            xoff_byte = value;
        end else begin
            raw_on = value[0];
        end
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    // Random phase: mostly well-formed output runs and receive bursts, some noise.
    // Items are added until the running item total reaches goal.
    task automatic build_random_phase(input int goal, input bit with_full_store);
        line_item_t it;
        int         k;
        int         n_tx;
        bit         full_pending;
        full_pending = with_full_store;
        while (items_built < goal) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: begin
                    // Output run: usually raise CTS, load bytes with a last marker, give send chances.
                    it = random_item(KIND_MODEM);
                    it.cts = ($urandom_range(0, 9) != 0);
                    it.carrier_delta = ($urandom_range(0, 7) == 0);
                    queue_item(it);
                    if (full_pending) begin
                        k = $urandom_range(OUT_DEPTH - 1, OUT_DEPTH + 3);
                        full_pending = 1'b0;
                    end else begin
                        k = $urandom_range(1, 6);
                    end
                    for (int j = 0; j < k; j++) begin
                        it = random_item(KIND_LOAD);
                        it.flag = (j == k - 1);
                        queue_item(it);
                    end
                    n_tx = $urandom_range(0, k + 2);
                    for (int j = 0; j < n_tx; j++) begin
                        case ($urandom_range(0, 19))
                            0: it = random_item(KIND_INHIBIT);
                            1: begin
                                it = random_item(KIND_RX_BYTE);
                                if ($urandom_range(0, 1)) it.data_byte = xoff_byte;
                            end
                            2: it = random_item(KIND_LOAD);
                            default: it = random_item(KIND_TX_EMPTY);
                        endcase
                        queue_item(it);
                    end
                    if ($urandom_range(0, 1)) queue_item(random_item(KIND_CANCEL));
                end
                4, 5, 6: begin
                    // Receive burst, sometimes past the high-water mark or the store size.
                    if ($urandom_range(0, 3) == 0) begin
                        k = $urandom_range(HIGH_MARK - 4, IN_DEPTH + 8);
                    end else begin
                        k = $urandom_range(1, 8);
                    end
                    for (int j = 0; j < k; j++) begin
                        it = random_item(KIND_RX_BYTE);
                        if ($urandom_range(0, 4) == 0) it.data_byte = xoff_byte;
                        queue_item(it);
                    end
                    if ($urandom_range(0, 3) == 0) queue_item(random_item(KIND_CREADY));
                    if ($urandom_range(0, 9) < 7) queue_item(random_item(KIND_DRAIN));
                end
                7: begin
                    queue_item(random_item(KIND_MODEM));
                    queue_item(random_item(KIND_HUPQ));
                end
                8: begin
                    queue_item(random_item($urandom_range(KIND_INHIBIT, KIND_CREADY)));
                end
                default: begin
                    queue_item(random_item($urandom_range(0, KIND_TOP)));
                end
            endcase
        end
    endtask

    // Reset, directed checks, then random phases under several register settings.
    initial begin : stimulus
        logic [7:0] xoff_plan[6];
        logic       raw_plan[6];
        xoff_plan = '{8'd0, 8'd255, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                      8'd255, 8'd0};
        raw_plan  = '{1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};

        xoff_byte    = XOFF_RESET;
        raw_on       = RAW_RESET;
        rx_fill      = 0;
        tx_head      = 0;
        tx_tail      = 0;
        rts_now      = 1'b1;
        reader_ready = 1'b1;
        lflags       = FLAGS_RESET;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part in raw mode: output path, received bytes, drains, inhibit, reader ready, hangup, unknown kinds.
        @(negedge aclk);
        queue_item(line_item(KIND_HUPQ, 8'h00, 0, 0, 0, 0, 0));
        queue_item(line_item(KIND_MODEM, 8'h00, 0, 1, 1, 1, 0));
        queue_item(line_item(KIND_LOAD, 8'h00, 0, 0, 0, 0, 0));
        queue_item(line_item(KIND_LOAD, 8'hFF, 1, 1, 0, 0, 0));
        queue_item(line_item(KIND_LOAD, 8'h55, 1, 1, 0, 0, 0));
        queue_item(line_item(KIND_TX_EMPTY, 8'h00, 0, 0, 0, 0, 0));
        queue_item(line_item(KIND_CANCEL, 8'h00, 0, 0, 0, 0, 0));
        queue_item(line_item(KIND_RX_BYTE, 8'h00, 0, 0, 0, 0, 0));
        queue_item(line_item(KIND_RX_BYTE, 8'hFF, 0, 0, 0, 0, 0));
        queue_item(line_item(KIND_RX_BYTE, XOFF_RESET, 0, 0, 0, 0, 0));
        queue_item(line_item(KIND_DRAIN, 8'h00, 0, 0, 0, 0, 0));
        queue_item(line_item(KIND_DRAIN, 8'h00, 0, 0, 0, 0, 0));
        queue_item(line_item(KIND_INHIBIT, 8'h00, 1, 0, 0, 0, 0));
        queue_item(line_item(KIND_LOAD, 8'hA5, 1, 1, 0, 0, 0));
        queue_item(line_item(KIND_INHIBIT, 8'h00, 0, 0, 0, 0, 0));
        queue_item(line_item(KIND_TX_EMPTY, 8'h00, 0, 0, 0, 0, 0));
        queue_item(line_item(KIND_CANCEL, 8'h00, 0, 0, 0, 0, 0));
        queue_item(line_item(KIND_CREADY, 8'h00, 0, 0, 0, 0, 0));
        queue_item(line_item(KIND_CREADY, 8'h00, 1, 0, 0, 0, 0));
        queue_item(line_item(KIND_MODEM, 8'h00, 0, 0, 0, 0, 1));
        queue_item(line_item(KIND_HUPQ, 8'h00, 0, 0, 0, 0, 0));
        queue_item(line_item(KIND_HUPQ, 8'h00, 0, 0, 0, 0, 0));
        queue_item(line_item(S_TUSER_W'(KIND_TOP), 8'h00, 0, 0, 0, 0, 0));
        queue_item(line_item(KIND_HUPQ + 1'b1, 8'h00, 0, 0, 0, 0, 0));
        settle_idle();

        // XOFF pause and resume by another received byte.
        set_reg(CFG_RAW_MODE, 8'd0);
        @(negedge aclk);
        queue_item(line_item(KIND_MODEM, 8'h00, 0, 0, 1, 1, 0));
        queue_item(line_item(KIND_RX_BYTE, XOFF_RESET, 0, 0, 0, 0, 0));
        queue_item(line_item(KIND_LOAD, 8'h11, 0, 0, 0, 0, 0));
        queue_item(line_item(KIND_LOAD, 8'h22, 1, 1, 0, 0, 0));
        queue_item(line_item(KIND_RX_BYTE, 8'h41, 0, 1, 0, 0, 0));
        queue_item(line_item(KIND_TX_EMPTY, 8'h00, 0, 0, 0, 0, 0));
        queue_item(line_item(KIND_CANCEL, 8'h00, 0, 0, 0, 0, 0));
        settle_idle();

        // Each phase takes an even share of the items still left in the budget.
        for (int p = 0; p < 6; p++) begin
            set_reg(CFG_XOFF_CHAR, xoff_plan[p]);
            set_reg(CFG_RAW_MODE, {7'd0, raw_plan[p]});
            @(negedge aclk);
            build_random_phase(items_built + (ITEM_GOAL - items_built) / (6 - p), p == 2);
            settle_idle();
        end

        if (awaited_replies.size() != 0) begin
            note_mismatch($sformatf("%0d results never arrived", awaited_replies.size()));
        end
        if (err_count == 0) begin
            $display("serial_flow_control_engine_top_tb: done, clean");
        end else begin
            $display("serial_flow_control_engine_top_tb: done, errors");
        end
        $finish;
    end

endmodule
